### hw/rtl/circular_deque_engine_top_macros.svh
// Assertion macros shared by the deque engine modules.
// Needs clock aclk and active-low reset aresetn in the module that uses them.
`ifndef CIRCULAR_DEQUE_ENGINE_TOP_MACROS_SVH
`define CIRCULAR_DEQUE_ENGINE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cde_pkg.sv
// Shared types and constants of the circular deque engine.
// No dependencies; used by the controller, the datapath and the top level.
package cde_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ITEM_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int STATUS_W  = 2;

    // Command codes.
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_REAR  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_REAR   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LIST       = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Ring address selection: offsets from the front pointer.
    localparam logic [2:0] ADDR_FRONT_DEC = 3'd0; // one slot before the front
    localparam logic [2:0] ADDR_REAR_FREE = 3'd1; // first free slot after the rear
    localparam logic [2:0] ADDR_FRONT     = 3'd2;
    localparam logic [2:0] ADDR_REAR      = 3'd3;
    localparam logic [2:0] ADDR_LIST      = 3'd4;

    typedef struct packed {
        logic                cap;
        logic                ram_wr;
        logic                ram_rd;
        logic [2:0]          addr_sel;
        logic                front_dec;
        logic                front_inc;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                idx_clr;
        logic                idx_inc;
        logic                out_load;
        logic                out_from_ram;
        logic [STATUS_W-1:0] out_status;
        logic                out_last;
    } cde_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              empty;
        logic              idx_last;
        logic              out_free;
    } cde_stat_t;

endpackage

### hw/rtl/cde_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/cde_dp.sv
// Datapath of the deque engine: command register, front pointer, item count,
// list index, ring RAM and the result register. Depends on cde_pkg and cde_ram.
`include "circular_deque_engine_top_macros.svh"

module cde_dp import cde_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cde_cmd_t            cmd,
    output cde_stat_t           stat,
    input  logic [FUNC_W-1:0]   in_func,
    input  logic [ITEM_W-1:0]   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ITEM_W-1:0]   out_value,
    output logic [STATUS_W-1:0] out_status,
    output logic                out_last
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [FUNC_W-1:0]   func_reg;
    logic [ITEM_W-1:0]   item_reg;
    logic [PW-1:0]       front_reg, front_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                valid_reg, valid_next;
    logic [ITEM_W-1:0]   value_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                last_reg;

    logic [CW-1:0]   offset;
    logic [SW-1:0]   sum;
    logic [SW-1:0]   wrapped;
    logic [PW-1:0]   ring_addr;
    logic [PW-1:0]   front_dec;
    logic [PW-1:0]   front_inc;
    logic [ITEM_W-1:0] rd_data;

    // Every ring address is the front pointer plus an offset below twice DEPTH.
    always_comb begin
        case (cmd.addr_sel)
            ADDR_FRONT_DEC: offset = CW'(DEPTH - 1);
            ADDR_REAR_FREE: offset = count_reg;
            ADDR_FRONT:     offset = '0;
            ADDR_REAR:      offset = count_reg - CW'(1);
            ADDR_LIST:      offset = idx_reg;
            default:        offset = '0;
        endcase
        sum       = SW'(front_reg) + SW'(offset);
        wrapped   = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
        ring_addr = wrapped[PW-1:0];
        front_dec = (front_reg == '0) ? PW'(DEPTH - 1) : (front_reg - PW'(1));
        front_inc = (front_reg == PW'(DEPTH - 1)) ? '0 : (front_reg + PW'(1));
    end

    cde_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.ram_wr),
        .wr_addr (ring_addr),
        .wr_data (item_reg),
        .rd_en   (cmd.ram_rd),
        .rd_addr (ring_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        front_next = front_reg;
        if (cmd.front_dec) begin
            front_next = front_dec;
        end else if (cmd.front_inc) begin
            front_next = front_inc;
        end

        count_next = count_reg;
        if (cmd.cnt_inc) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - CW'(1);
        end

        idx_next = idx_reg;
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + CW'(1);
        end

        valid_next = valid_reg;
        if (cmd.out_load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            front_reg <= front_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            func_reg <= in_func;
            item_reg <= in_item;
        end
        if (cmd.out_load) begin
            value_reg  <= cmd.out_from_ram ? rd_data : '0;
            status_reg <= cmd.out_status;
            last_reg   <= cmd.out_last;
        end
    end

    assign stat.func     = func_reg;
    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.empty    = (count_reg == '0);
    assign stat.idx_last = ((idx_reg + CW'(1)) == count_reg);
    assign stat.out_free = !valid_reg || out_ready;

    assign out_valid  = valid_reg;
    assign out_value  = value_reg;
    assign out_status = status_reg;
    assign out_last   = last_reg;

    `CDE_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(DEPTH), "item count above depth")
    `CDE_ASSERT_NOW(a_no_write_full, cmd.ram_wr, count_reg < CW'(DEPTH), "write into full ring")
    `CDE_ASSERT_NOW(a_no_pop_empty, cmd.cnt_dec, count_reg != '0, "pop from empty ring")

endmodule

### hw/rtl/cde_ctrl.sv
// Controller state machine of the deque engine: sequences accept, ring access
// and result loading for each command. Depends on cde_pkg.
`include "circular_deque_engine_top_macros.svh"

module cde_ctrl import cde_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  cde_stat_t stat,
    output cde_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_DECODE    = 3'd1;
    localparam logic [2:0] ST_POP_WAIT  = 3'd2;
    localparam logic [2:0] ST_LIST_RD   = 3'd3;
    localparam logic [2:0] ST_LIST_WAIT = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.cap  = in_valid;
                if (in_valid) begin
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE: begin
                case (stat.func)
                    FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
                        // A push finishes in this cycle, so it waits for the result slot.
                        if (stat.out_free) begin
                            cmd.out_load = 1'b1;
                            cmd.out_last = 1'b1;
                            if (stat.full) begin
                                cmd.out_status = STATUS_FULL;
                            end else begin
                                cmd.out_status = STATUS_OK;
                                cmd.ram_wr     = 1'b1;
                                cmd.cnt_inc    = 1'b1;
                                if (stat.func == FUNC_PUSH_FRONT) begin
                                    cmd.addr_sel  = ADDR_FRONT_DEC;
                                    cmd.front_dec = 1'b1;
                                end else begin
                                    cmd.addr_sel = ADDR_REAR_FREE;
                                end
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    FUNC_POP_FRONT, FUNC_POP_REAR: begin
                        if (stat.empty) begin
                            if (stat.out_free) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_last   = 1'b1;
                                cmd.out_status = STATUS_EMPTY;
                                state_next     = ST_IDLE;
                            end
                        end else begin
                            cmd.ram_rd  = 1'b1;
                            cmd.cnt_dec = 1'b1;
                            if (stat.func == FUNC_POP_FRONT) begin
                                cmd.addr_sel  = ADDR_FRONT;
                                cmd.front_inc = 1'b1;
                            end else begin
                                cmd.addr_sel = ADDR_REAR;
                            end
                            state_next = ST_POP_WAIT;
                        end
                    end
                    FUNC_LIST: begin
                        if (stat.empty) begin
                            if (stat.out_free) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_last   = 1'b1;
                                cmd.out_status = STATUS_EMPTY;
                                state_next     = ST_IDLE;
                            end
                        end else begin
                            cmd.idx_clr = 1'b1;
                            state_next  = ST_LIST_RD;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_POP_WAIT: begin
                // The RAM holds its read data until the result slot frees up.
                if (stat.out_free) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_from_ram = 1'b1;
                    cmd.out_status   = STATUS_OK;
                    cmd.out_last     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            ST_LIST_RD: begin
                cmd.ram_rd   = 1'b1;
                cmd.addr_sel = ADDR_LIST;
                state_next   = ST_LIST_WAIT;
            end

            ST_LIST_WAIT: begin
                if (stat.out_free) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_from_ram = 1'b1;
                    cmd.out_status   = STATUS_OK;
                    cmd.out_last     = stat.idx_last;
                    if (stat.idx_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_LIST_RD;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `CDE_ASSERT_NOW(a_load_when_free, cmd.out_load, stat.out_free, "result overwritten")
    `CDE_ASSERT_NEXT(a_cap_to_decode, cmd.cap, state_reg == ST_DECODE, "accepted item not decoded")
    `CDE_ASSERT_NOW(a_list_nonempty, state_reg == ST_LIST_RD, !stat.empty, "list walk on empty ring")

endmodule

### hw/rtl/circular_deque_engine_top.sv
// Circular deque engine: a bounded double-ended queue of signed 32-bit items.
// Input channel s_*: s_tuser[2:0] = func (0 push front, 1 push rear,
// 2 pop front, 3 pop rear, 4 list all; 5..7 are ignored), s_tdata = item.
// Result channel m_*: m_tdata = value, m_tuser[1:0] = status (0 ok,
// 1 empty, 2 full and push dropped), m_tlast = last result of the command.
// Each command is taken one at a time; s_tready is high only while idle.
// A push loads its result in the decode state that follows acceptance; a
// pop first reads the ring RAM there and loads the read data in a wait state.
// A list of N items gives N results from front to rear: each item is one RAM
// read followed by one load of the result register, using the single read port.
// Empty and full cases give one result from the decode state; unknown codes none.
// When m_tready is low the result register holds and the controller waits
// before loading the next result, so no item is lost or repeated.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result. The ring RAM itself is not cleared; only written entries are read.
// Depends on cde_pkg, cde_ctrl, cde_dp and cde_ram.
module circular_deque_engine_top import cde_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] item
    input  logic [2:0]  s_tuser,   // [2:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    cde_cmd_t  cmd;
    cde_stat_t stat;

    cde_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cde_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_func    (s_tuser),
        .in_item    (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (m_tdata),
        .out_status (m_tuser),
        .out_last   (m_tlast)
    );

endmodule

### dv/tb_circular_deque_engine_top.sv
// Testbench for circular_deque_engine_top: directed and random deque commands,
// with each result checked against a deque mirror kept in the testbench.
// Depends on cde_pkg and the engine RTL only.
module tb_circular_deque_engine_top import cde_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_SIZE      = DEPTH_DEF;
    localparam int STALL_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 2 * RING_SIZE + 8;
    localparam int RANDOM_ITEMS   = 275;

    typedef struct packed {
        logic [ITEM_W-1:0]   value;
        logic [STATUS_W-1:0] status;
        logic                last;
    } deque_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata  = '0;
    logic [2:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;

    // Deque mirror and the results it predicts, oldest first.
    logic [ITEM_W-1:0]   ring_mirror [RING_SIZE];
    int unsigned         head_idx   = 0;
    int unsigned         fill_count = 0;
    deque_result_t       expected_results [$];

    int unsigned         mismatch_count = 0;
    int unsigned         quiet_cycles   = 0;
    logic                no_stall       = 1'b0;

    circular_deque_engine_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    function automatic void add_result(input logic [ITEM_W-1:0] value,
                                       input logic [STATUS_W-1:0] status,
                                       input logic last);
        deque_result_t r;
        r.value  = value;
        r.status = status;
        r.last   = last;
        expected_results.push_back(r);
    endfunction

    // Applies one accepted command to the mirror and queues its results.
    function automatic void apply_deque_command(input logic [FUNC_W-1:0] func,
                                                input logic [ITEM_W-1:0] item);
        int unsigned slot;
        case (func)
            FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
                if (fill_count >= RING_SIZE) begin
                    add_result('0, STATUS_FULL, 1'b1);
                end else begin
                    if (func == FUNC_PUSH_FRONT) begin
                        head_idx = (head_idx + RING_SIZE - 1) % RING_SIZE;
                        ring_mirror[head_idx] = item;
                    end else begin
                        ring_mirror[(head_idx + fill_count) % RING_SIZE] = item;
                    end
                    fill_count++;
                    add_result('0, STATUS_OK, 1'b1);
                end
            end
            FUNC_POP_FRONT, FUNC_POP_REAR: begin
                if (fill_count == 0) begin
                    add_result('0, STATUS_EMPTY, 1'b1);
                end else if (func == FUNC_POP_FRONT) begin
                    add_result(ring_mirror[head_idx], STATUS_OK, 1'b1);
                    head_idx = (head_idx + 1) % RING_SIZE;
                    fill_count--;
                end else begin
                    slot = (head_idx + fill_count - 1) % RING_SIZE;
                    add_result(ring_mirror[slot], STATUS_OK, 1'b1);
                    fill_count--;
                end
            end
            FUNC_LIST: begin
                if (fill_count == 0) begin
                    add_result('0, STATUS_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < fill_count; i++) begin
                        add_result(ring_mirror[(head_idx + i) % RING_SIZE], STATUS_OK,
                                   (i + 1 == fill_count));
                    end
                end
            end
            default: ; // codes above the list command are dropped by the block
        endcase
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            apply_deque_command(s_tuser, s_tdata);
        end
    end

    always @(posedge aclk) begin : check_results
        deque_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected: value %h status %0d last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata !== want.value) begin
                    $display("%0t: value mismatch: expected %h, actual %h",
                             $time, want.value, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Result-side back-pressure: about one stalled cycle in five unless no_stall is set.
    always @(posedge aclk) begin
        m_tready <= no_stall || ($urandom_range(99) >= 20);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one command and returns at the edge where it is taken.
    task automatic send_command(input logic [FUNC_W-1:0] func,
                                input logic [ITEM_W-1:0] item);
        if (!no_stall && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= item;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_until_drained(input int unsigned settle);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic test_empty_queue();
        send_command(FUNC_POP_FRONT, 32'hFFFF_FFFF);
        send_command(FUNC_POP_REAR, 32'h0000_0000);
        send_command(FUNC_LIST, 32'h1234_5678);
        // Unused codes must be swallowed without any result.
        send_command(3'd5, 32'hDEAD_BEEF);
        send_command(3'd6, 32'h0000_0001);
        send_command(3'd7, 32'h8000_0000);
    endtask

    task automatic test_fill_to_full();
        logic [ITEM_W-1:0] corner [4] = '{32'h8000_0000, 32'h7FFF_FFFF,
                                          32'hFFFF_FFFF, 32'h0000_0000};
        // Front pushes wrap the front index below zero right away.
        for (int i = 0; i < RING_SIZE / 2; i++) begin
            send_command(FUNC_PUSH_FRONT, (i < 4) ? corner[i] : $urandom());
        end
        for (int i = 0; i < RING_SIZE / 2; i++) begin
            send_command(FUNC_PUSH_REAR, (i == 0) ? 32'hAAAA_AAAA :
                                         (i == 1) ? 32'h5555_5555 : $urandom());
        end
        send_command(FUNC_PUSH_FRONT, 32'h0BAD_F00D);
        send_command(FUNC_PUSH_REAR, 32'hF00D_0BAD);
        send_command(FUNC_LIST, '0);
        send_command(FUNC_POP_FRONT, '0);
        send_command(FUNC_POP_REAR, '0);
    endtask

    function automatic logic [ITEM_W-1:0] pick_item();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Alternating fill and drain phases swing the deque between empty and full
    // so the front index wraps both ways and both limits are hit often.
    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned roll;
        bit          growing;
        logic [FUNC_W-1:0] func;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            growing = ((sent / 40) % 2) == 0;
            roll = $urandom_range(99);
            if (roll < 4) begin
                func = FUNC_W'($urandom_range(7, 5));
            end else if (roll < 12) begin
                func = FUNC_LIST;
            end else if ($urandom_range(99) < (growing ? 70 : 30)) begin
                func = $urandom_range(1) ? FUNC_PUSH_FRONT : FUNC_PUSH_REAR;
            end else begin
                func = $urandom_range(1) ? FUNC_POP_FRONT : FUNC_POP_REAR;
            end
            send_command(func, pick_item());
            if (func <= FUNC_LIST) begin
                sent++;
            end
            if (sent == 90) begin
                no_stall <= 1'b1;
            end else if (sent == 160) begin
                no_stall <= 1'b0;
            end else if (sent == 200) begin
                // Hold off new commands until the block has caught up.
                wait_until_drained(8);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_queue();
        test_fill_to_full();
        test_random_traffic();

        wait_until_drained(SETTLE_CYCLES);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
